[sv/icdf_pkg.sv]
package icdf_pkg;

    localparam int OP_W        = 1;
    localparam int INDEX_W     = 6;
    localparam int CDF_W       = 25;
    localparam int EDGE_W      = 32;
    localparam int U_W         = 24;
    localparam int NUM_PTS_W   = 7;
    localparam int STATUS_W    = 2;
    localparam int PROD_W      = U_W + EDGE_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int DIV_CNT_W   = 6;

    localparam logic [NUM_PTS_W-1:0] NUM_PTS_RESET = 7'd2;
    localparam logic [NUM_PTS_W-1:0] NUM_PTS_MIN   = 7'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP = 2'd0,
        ST_LOW    = 2'd1,
        ST_HIGH   = 2'd2,
        ST_WRITE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_FIX,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    start;
        logic    mem_wr;
        logic    rd_en;
        logic    load_first;
        logic    shift_prev;
        logic    seg_load;
        logic    mul_load;
        logic    div_init;
        logic    div_step;
        logic    fix_load;
        logic    out_load;
        status_t out_status;
    } icdf_cmd_t;

    typedef struct packed {
        logic seg_hit;
        logic below_first;
    } icdf_stat_t;

endpackage

[sv/icdf_datapath.sv]
module icdf_datapath
    import icdf_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  icdf_cmd_t           cmd,
    input  logic [AW-1:0]       rd_addr,
    output icdf_stat_t          stat,
    input  logic [INDEX_W-1:0]  point_index,
    input  logic [CDF_W-1:0]    cdf_value,
    input  logic [EDGE_W-1:0]   edge_value,
    input  logic [U_W-1:0]      uniform_value,
    output logic [EDGE_W-1:0]   sample_value,
    output logic [STATUS_W-1:0] status
);

    logic [CDF_W-1:0]  cdf_mem  [MAX_POINTS];
    logic [EDGE_W-1:0] edge_mem [MAX_POINTS];

    logic [CDF_W-1:0]  rd_cdf_reg;
    logic [EDGE_W-1:0] rd_edge_reg;
    logic [U_W-1:0]    u_reg;
    logic [CDF_W-1:0]  first_cdf_reg;
    logic [EDGE_W-1:0] first_edge_reg;
    logic [CDF_W-1:0]  prev_cdf_reg;
    logic [EDGE_W-1:0] prev_edge_reg;
    logic [U_W-1:0]    num_reg;
    logic [CDF_W-1:0]  den_reg;
    logic [EDGE_W-1:0] e0_reg;
    logic [EDGE_W-1:0] diff_reg;
    logic              down_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [U_W-1:0]    rem_reg;
    logic [EDGE_W-1:0] interp_reg;
    logic [EDGE_W-1:0] sample_value_reg;
    status_t           status_reg;

    logic              wr_ok;
    logic [CDF_W-1:0]  u_ext;
    logic              seg_down;
    logic [CDF_W-1:0]  trial;
    logic [CDF_W-1:0]  trial_sub;
    logic              trial_ge;
    logic [EDGE_W-1:0] q_fix;
    logic [EDGE_W-1:0] interp_next;
    logic [EDGE_W-1:0] sample_value_next;

    assign wr_ok = (32'(point_index) < MAX_POINTS);
    assign u_ext = {1'b0, u_reg};

    assign stat.seg_hit     = (prev_cdf_reg <= u_ext) && (u_ext < rd_cdf_reg);
    assign stat.below_first = (u_ext < first_cdf_reg);

    assign seg_down = (rd_edge_reg < prev_edge_reg);

    // restoring division, one quotient bit per step
    assign trial     = {rem_reg, quo_reg[PROD_W-1]};
    assign trial_ge  = (trial >= den_reg);
    assign trial_sub = trial - den_reg;

    // falling segment: quotient rounded up so the result floors toward minus infinity
    assign q_fix       = quo_reg[EDGE_W-1:0] + EDGE_W'(down_reg && (rem_reg != '0));
    assign interp_next = down_reg ? (e0_reg - q_fix) : (e0_reg + q_fix);

    always_comb
    begin
        unique case (cmd.out_status)
            ST_WRITE:  sample_value_next = '0;
            ST_LOW:    sample_value_next = first_edge_reg;
            ST_HIGH:   sample_value_next = prev_edge_reg;
            ST_INTERP: sample_value_next = interp_reg;
            default:   sample_value_next = interp_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_ok)
        begin
            cdf_mem[AW'(point_index)]  <= cdf_value;
            edge_mem[AW'(point_index)] <= edge_value;
        end
        if (cmd.rd_en)
        begin
            rd_cdf_reg  <= cdf_mem[rd_addr];
            rd_edge_reg <= edge_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg            <= '0;
            first_cdf_reg    <= '0;
            first_edge_reg   <= '0;
            prev_cdf_reg     <= '0;
            prev_edge_reg    <= '0;
            num_reg          <= '0;
            den_reg          <= '0;
            e0_reg           <= '0;
            down_reg         <= 1'b0;
            diff_reg         <= '0;
            prod_reg         <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            interp_reg       <= '0;
            sample_value_reg <= '0;
            status_reg       <= ST_WRITE;
        end
        else
        begin
            if (cmd.start)
            begin
                u_reg <= uniform_value;
            end
            if (cmd.load_first)
            begin
                first_cdf_reg  <= rd_cdf_reg;
                first_edge_reg <= rd_edge_reg;
            end
            if (cmd.shift_prev)
            begin
                prev_cdf_reg  <= rd_cdf_reg;
                prev_edge_reg <= rd_edge_reg;
            end
            if (cmd.seg_load)
            begin
                num_reg  <= u_reg - prev_cdf_reg[U_W-1:0];
                den_reg  <= rd_cdf_reg - prev_cdf_reg;
                e0_reg   <= prev_edge_reg;
                down_reg <= seg_down;
                diff_reg <= seg_down ? (prev_edge_reg - rd_edge_reg)
                                     : (rd_edge_reg - prev_edge_reg);
            end
            if (cmd.mul_load)
            begin
                prod_reg <= PROD_W'(num_reg) * PROD_W'(diff_reg);
            end
            if (cmd.div_init)
            begin
                quo_reg <= prod_reg;
                rem_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg <= {quo_reg[PROD_W-2:0], trial_ge};
                rem_reg <= trial_ge ? trial_sub[U_W-1:0] : trial[U_W-1:0];
            end
            if (cmd.fix_load)
            begin
                interp_reg <= interp_next;
            end
            if (cmd.out_load)
            begin
                sample_value_reg <= sample_value_next;
                status_reg       <= cmd.out_status;
            end
        end
    end

    assign sample_value = sample_value_reg;
    assign status       = status_reg;

endmodule

[sv/icdf_ctrl.sv]
module icdf_ctrl
    import icdf_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      op,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [NUM_PTS_W-1:0] cfg_data,
    output icdf_cmd_t            cmd,
    output logic [AW-1:0]        rd_addr,
    input  icdf_stat_t           stat
);

    state_t                state_reg, state_next;
    logic [NUM_PTS_W-1:0]  num_points_reg;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         issue_idx_reg, issue_idx_next;
    logic [CW-1:0]         rd_pos_reg, rd_pos_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    status_t               res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CW-1:0]         n_clamped;
    logic                  issue;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign rd_addr   = issue_idx_reg[AW-1:0];

    // register keeps the written bits; clamping happens when a sample starts
    always_comb
    begin
        priority if (num_points_reg < NUM_PTS_MIN)
            n_clamped = CW'(NUM_PTS_MIN);
        else if (32'(num_points_reg) > MAX_POINTS)
            n_clamped = CW'(MAX_POINTS);
        else
            n_clamped = CW'(num_points_reg);
    end

    assign issue = (state_reg == S_SCAN) && (issue_idx_reg < n_reg);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        issue_idx_next  = issue_idx_reg;
        rd_pos_next     = rd_pos_reg;
        rd_valid_next   = 1'b0;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.out_status  = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (op_t'(op) == OP_WRITE)
                    begin
                        cmd.mem_wr      = 1'b1;
                        res_status_next = ST_WRITE;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        n_next         = n_clamped;
                        issue_idx_next = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // reads stream one point a cycle; each compare runs in the cycle after its read
                if (issue)
                begin
                    cmd.rd_en      = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                    rd_valid_next  = 1'b1;
                    rd_pos_next    = issue_idx_reg;
                end
                if (rd_valid_reg)
                begin
                    priority if (rd_pos_reg == '0)
                    begin
                        cmd.load_first = 1'b1;
                        cmd.shift_prev = 1'b1;
                    end
                    else if (stat.seg_hit)
                    begin
                        cmd.seg_load    = 1'b1;
                        res_status_next = ST_INTERP;
                        state_next      = S_MUL;
                    end
                    else
                    begin
                        cmd.shift_prev = 1'b1;
                        if (rd_pos_reg == n_reg - 1'b1)
                        begin
                            res_status_next = stat.below_first ? ST_LOW : ST_HIGH;
                            state_next      = S_RESULT;
                        end
                    end
                end
            end

            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DINIT;
            end

            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_FIX;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end

            S_FIX:
            begin
                cmd.fix_load = 1'b1;
                state_next   = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_points_reg <= NUM_PTS_RESET;
            n_reg          <= '0;
            issue_idx_reg  <= '0;
            rd_pos_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            res_status_reg <= ST_WRITE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            issue_idx_reg  <= issue_idx_next;
            rd_pos_reg     <= rd_pos_next;
            rd_valid_reg   <= rd_valid_next;
            div_cnt_reg    <= div_cnt_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                num_points_reg <= cfg_data;
            end
        end
    end

endmodule

[sv/inverse_cdf_table_sampler_top.sv]
// Write: the point is stored, then the result register loads. Sample: the table is
// scanned one point a cycle over the n points in use; a clamped result loads when
// the scan ends, an interpolated one after one multiply and a 56-step restoring divide.
// One item in flight; the next is taken the cycle after the result register loads.
// Reset: async active low; num_points returns to 2, table contents undefined.
module inverse_cdf_table_sampler_top
    import icdf_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      op,
    input  logic [INDEX_W-1:0]   point_index,
    input  logic [CDF_W-1:0]     cdf_value,
    input  logic [EDGE_W-1:0]    edge_value,
    input  logic [U_W-1:0]       uniform_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [EDGE_W-1:0]    sample_value,
    output logic [STATUS_W-1:0]  status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [NUM_PTS_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    icdf_cmd_t     cmd;
    icdf_stat_t    stat;
    logic [AW-1:0] rd_addr;

    icdf_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .stat      (stat)
    );

    icdf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .stat          (stat),
        .point_index   (point_index),
        .cdf_value     (cdf_value),
        .edge_value    (edge_value),
        .uniform_value (uniform_value),
        .sample_value  (sample_value),
        .status        (status)
    );

endmodule
